/* hdl/fla_pkg.sv */
// Shared types and constants for the fixed-latency load admission block.
// Used by the configuration registers, the slot cells and the sequencer.
// No dependencies.
`default_nettype none

package fla_pkg;

  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned LIMIT_W  = 17;
  localparam int unsigned BLEN_W   = 8;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned WAIT_W   = 8;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_PIPE_LEN   = 1'b0;
  localparam logic REG_LOAD_LIMIT = 1'b1;

  localparam logic [BLEN_W-1:0]  PIPE_LEN_RST   = 8'd2;
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 17'd10;

  typedef struct packed {
    logic [BLEN_W-1:0]  pipe_len;
    logic [LIMIT_W-1:0] load_limit;
  } fla_cfg_t;

  // Per-cycle command from the sequencer to the row of slot cells.
  typedef struct packed {
    logic pop;   // oldest slot leaves, every cell but a pushed one takes its upper neighbor
    logic push;  // a slot value is written at the tail
  } fla_chain_ctl_t;

endpackage

`default_nettype wire

/* hdl/fla_cfg.sv */
// APB-style configuration registers: pipe length and load limit.
// Depends on fla_pkg.
`default_nettype none

module fla_cfg
  import fla_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output fla_cfg_t               cfg_o
);

  logic [BLEN_W-1:0]  pipe_len_q, pipe_len_d;
  logic [LIMIT_W-1:0] load_limit_q, load_limit_d;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    pipe_len_d   = pipe_len_q;
    load_limit_d = load_limit_q;
    if (wr_en) begin
      case (paddr[2])
        REG_PIPE_LEN:   pipe_len_d   = pwdata[BLEN_W-1:0];
        REG_LOAD_LIMIT: load_limit_d = pwdata[LIMIT_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PIPE_LEN:   prdata = DATA_W'(pipe_len_q);
      REG_LOAD_LIMIT: prdata = DATA_W'(load_limit_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_len_q   <= PIPE_LEN_RST;
      load_limit_q <= LOAD_LIMIT_RST;
    end else begin
      pipe_len_q   <= pipe_len_d;
      load_limit_q <= load_limit_d;
    end
  end

  assign cfg_o.pipe_len   = pipe_len_q;
  assign cfg_o.load_limit = load_limit_q;

endmodule

`default_nettype wire

/* hdl/fla_cell.sv */
// One slot of the in-flight pipe: holds one weight, shifts toward the head on a pop.
// Depends on fla_pkg.
`default_nettype none

module fla_cell
  import fla_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 7
) (
  input  wire logic                  clk_i,
  input  wire fla_chain_ctl_t        ctl_i,
  input  wire logic [IW-1:0]         push_idx_i,
  input  wire logic [WEIGHT_W-1:0]   push_w_i,
  input  wire logic [WEIGHT_W-1:0]   next_w_i,
  output logic      [WEIGHT_W-1:0]   w_o
);

  logic [WEIGHT_W-1:0] w_q, w_d;

  // The tail write wins over the shift: with a pop the tail index already
  // points one below the old tail.
  always_comb begin
    w_d = w_q;
    if (ctl_i.push && (push_idx_i == IW'(IDX))) begin
      w_d = push_w_i;
    end else if (ctl_i.pop) begin
      w_d = next_w_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  assign w_o = w_q;

endmodule

`default_nettype wire

/* hdl/fla_seq.sv */
// Admission sequencer: run state, load sum, tick count, wait loop and result register.
// Depends on fla_pkg; drives the row of fla_cell slots.
`default_nettype none

module fla_seq
  import fla_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 128,
  parameter int unsigned LW = 8,
  parameter int unsigned IW = 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fla_cfg_t            cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [WEIGHT_W-1:0] in_weight_i,
  input  wire logic                in_first_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [TICK_W-1:0]        out_entry_o,
  output logic [WAIT_W-1:0]        out_waited_o,
  output logic [TICK_W-1:0]        out_drain_o,
  output logic                     out_rejected_o,
  input  wire logic [WEIGHT_W-1:0] head_w_i,
  output fla_chain_ctl_t           ctl_o,
  output logic [IW-1:0]            push_idx_o,
  output logic [WEIGHT_W-1:0]      push_w_o
);

  localparam int unsigned CW = (LW > BLEN_W) ? LW : BLEN_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [WEIGHT_W-1:0] w_q, w_d;
  logic [LW-1:0]       occ_q, occ_d;
  logic [LIMIT_W-1:0]  sum_q, sum_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [WAIT_W-1:0]   waited_q, waited_d;

  logic                out_valid_q, out_valid_d;
  logic [TICK_W-1:0]   out_entry_q, out_entry_d;
  logic [WAIT_W-1:0]   out_waited_q, out_waited_d;
  logic [TICK_W-1:0]   out_drain_q, out_drain_d;
  logic                out_rej_q, out_rej_d;

  logic [CW-1:0]       blen_w;
  logic [LW-1:0]       len;
  logic                out_free;
  logic                reject;
  logic                over_len;
  logic                at_len;
  logic [LIMIT_W-1:0]  sum_pop;
  logic [LIMIT_W-1:0]  sum_base;
  logic [LIMIT_W:0]    sum_try;
  logic                fits;
  logic [TICK_W-1:0]   tick_inc;
  logic [TICK_W:0]     drain_raw;

  // Effective pipe length: zero acts as one, anything above the cell count as the cell count.
  always_comb begin
    blen_w = CW'(cfg_i.pipe_len);
    if (blen_w == '0) begin
      len = LW'(1);
    end else if (blen_w > CW'(MAX_SLOTS)) begin
      len = LW'(MAX_SLOTS);
    end else begin
      len = LW'(blen_w);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign reject   = LIMIT_W'(w_q) > cfg_i.load_limit;
  assign over_len = occ_q > len;
  assign at_len   = occ_q == len;
  assign sum_pop  = sum_q - LIMIT_W'(head_w_i);
  assign sum_base = at_len ? sum_pop : sum_q;
  assign sum_try  = (LIMIT_W+1)'(sum_base) + (LIMIT_W+1)'(w_q);
  assign fits     = sum_try <= (LIMIT_W+1)'(cfg_i.load_limit);
  assign tick_inc = (&tick_q) ? tick_q : tick_q + TICK_W'(1);
  // Drain tick = tick + 1 + len, saturating; equals len added to the saturated entry tick.
  assign drain_raw = (TICK_W+1)'(tick_q) + (TICK_W+1)'(len) + (TICK_W+1)'(1);

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    w_d          = w_q;
    occ_d        = occ_q;
    sum_d        = sum_q;
    tick_d       = tick_q;
    waited_d     = waited_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_entry_d  = out_entry_q;
    out_waited_d = out_waited_q;
    out_drain_d  = out_drain_q;
    out_rej_d    = out_rej_q;
    ctl_o        = '0;
    push_w_o     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          w_d      = in_weight_i;
          waited_d = '0;
          state_d  = ST_RUN;
          if (in_first_i) begin
            occ_d  = '0;
            sum_d  = '0;
            tick_d = '0;
          end
        end
      end
      ST_RUN: begin
        if (reject) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_entry_d  = '0;
            out_waited_d = '0;
            out_drain_d  = '0;
            out_rej_d    = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if (over_len) begin
          // Pipe was shortened: drop the oldest slot, one per cycle.
          ctl_o.pop = 1'b1;
          occ_d     = occ_q - LW'(1);
          sum_d     = sum_pop;
        end else if (fits) begin
          if (out_free) begin
            ctl_o.pop    = at_len;
            ctl_o.push   = 1'b1;
            push_w_o     = w_q;
            occ_d        = at_len ? occ_q : occ_q + LW'(1);
            sum_d        = sum_try[LIMIT_W-1:0];
            tick_d       = tick_inc;
            out_valid_d  = 1'b1;
            out_entry_d  = tick_inc;
            out_waited_d = waited_q;
            out_drain_d  = drain_raw[TICK_W] ? '1 : drain_raw[TICK_W-1:0];
            out_rej_d    = 1'b0;
            state_d      = ST_IDLE;
          end
        end else begin
          // Item does not fit yet: advance the pipe with an empty slot.
          ctl_o.pop  = at_len;
          ctl_o.push = 1'b1;
          occ_d      = at_len ? occ_q : occ_q + LW'(1);
          sum_d      = sum_base;
          tick_d     = tick_inc;
          waited_d   = (&waited_q) ? waited_q : waited_q + WAIT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Tail index after an optional pop; below len whenever a push uses it, so it fits the index width.
  assign push_idx_o = IW'(occ_q - LW'(ctl_o.pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      sum_q       <= '0;
      tick_q      <= '0;
      waited_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      sum_q       <= sum_d;
      tick_q      <= tick_d;
      waited_q    <= waited_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q          <= w_d;
    out_entry_q  <= out_entry_d;
    out_waited_q <= out_waited_d;
    out_drain_q  <= out_drain_d;
    out_rej_q    <= out_rej_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_entry_o    = out_entry_q;
  assign out_waited_o   = out_waited_q;
  assign out_drain_o    = out_drain_q;
  assign out_rejected_o = out_rej_q;

endmodule

`default_nettype wire

/* hdl/fixed_latency_load_admission_top.sv */
// Top level of the fixed-latency load admission block.
// Depends on fla_pkg, fla_cfg, fla_cell and fla_seq.
//
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+-------------------------------------
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata[9:0] truck_weight, tuser first
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata entry/waited/drain, tuser rej.
// APB      | in        | psel/penable/pwrite, pready  | 0x0 pipe length, 0x4 load_limit
//
// An item is taken in the idle state. In the run state the sequencer first drops, one
// per cycle, any slots left past the end of a shortened pipe, then advances the cell
// chain by one empty slot per cycle until the item fits, and pushes it once the output
// register is free. A rejected item skips the pipe and waits only for that register.
// Reset clears the run state (occupancy, load sum, tick count) and the result valid;
// the slot cells hold no reset value and are only read once written.
// A stalled result waits in the output register; the next item is accepted meanwhile
// and finishes once the register is free.
`default_nettype none

module fixed_latency_load_admission_top
  import fla_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Input stream.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,   // [9:0] truck_weight, rest zero
  input  wire logic [0:0]        s_axis_tuser,   // [0] first
  // Result stream.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [71:0]            m_axis_tdata,   // [31:0] entry_tick, [39:32] waited_ticks,
                                                 // [71:40] drain_tick
  output logic [0:0]             m_axis_tuser,   // [0] rejected
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  // Occupancy counts up to MAX_SLOTS; cell indexes stop one below.
  localparam int unsigned LW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  fla_cfg_t            cfg;
  fla_chain_ctl_t      chain_ctl;
  logic [IW-1:0]       push_idx;
  logic [WEIGHT_W-1:0] push_w;
  logic [WEIGHT_W-1:0] cell_w [MAX_SLOTS];
  logic [TICK_W-1:0]   entry_tick;
  logic [WAIT_W-1:0]   waited_ticks;
  logic [TICK_W-1:0]   drain_tick;
  logic                rejected;

  fla_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Row of slot cells: cell 0 holds the oldest slot in flight; on every pop each cell but
  // the tail one being written takes its upper neighbor. The top cell shifts in zero.
  for (genvar gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
    logic [WEIGHT_W-1:0] next_w;
    if (gi == MAX_SLOTS - 1) begin : g_top
      assign next_w = '0;
    end else begin : g_mid
      assign next_w = cell_w[gi+1];
    end
    fla_cell #(
      .IDX (gi),
      .IW  (IW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (chain_ctl),
      .push_idx_i (push_idx),
      .push_w_i   (push_w),
      .next_w_i   (next_w),
      .w_o        (cell_w[gi])
    );
  end

  fla_seq #(
    .MAX_SLOTS (MAX_SLOTS),
    .LW        (LW),
    .IW        (IW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_weight_i    (s_axis_tdata[WEIGHT_W-1:0]),
    .in_first_i     (s_axis_tuser[0]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_entry_o    (entry_tick),
    .out_waited_o   (waited_ticks),
    .out_drain_o    (drain_tick),
    .out_rejected_o (rejected),
    .head_w_i       (cell_w[0]),
    .ctl_o          (chain_ctl),
    .push_idx_o     (push_idx),
    .push_w_o       (push_w)
  );

  assign m_axis_tdata = {drain_tick, waited_ticks, entry_tick};
  assign m_axis_tuser = rejected;

endmodule

`default_nettype wire

/* verif/fla_admission_checker.sv */
// Scoreboard for the fixed-latency load admission block: watches the input stream,
// the result stream and the APB port, predicts every result and compares field by field.
// Depends on fla_pkg for widths, register indexes and reset values.

module fla_admission_checker
  import fla_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [9:0] truck_weight, rest zero
  input  logic [0:0]        s_axis_tuser,   // [0] first
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [71:0]       m_axis_tdata,   // [31:0] entry_tick, [39:32] waited_ticks,
                                            // [71:40] drain_tick
  input  logic [0:0]        m_axis_tuser,   // [0] rejected
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       result_count_o,
  output int unsigned       reject_count_o,
  output int unsigned       empty_ticks_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TICK_W-1:0] entry_tick;
    logic [WAIT_W-1:0] waited_ticks;
    logic [TICK_W-1:0] drain_tick;
    logic              rejected;
  } admission_t;

  // Shadow copy of the registers and of the pipe.
  logic [BLEN_W-1:0]   shadow_length;
  logic [LIMIT_W-1:0]  shadow_limit;
  logic [WEIGHT_W-1:0] slot_weights [MAX_SLOTS];
  int unsigned         oldest_slot;
  int unsigned         slots_in_flight;
  logic [LIMIT_W-1:0]  inflight_weight;
  logic [TICK_W-1:0]   run_ticks;

  admission_t  expected_admissions [$];
  admission_t  predicted;
  admission_t  oldest;
  int unsigned fail_total;
  int unsigned results_seen;
  int unsigned rejects_seen;
  int unsigned empty_ticks_total;
  logic [DATA_W-1:0] readback_want;

  function automatic logic [TICK_W-1:0] add_saturating(input logic [TICK_W-1:0] a,
                                                       input logic [TICK_W-1:0] b);
    logic [TICK_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TICK_W] ? '1 : sum[TICK_W-1:0];
  endfunction

  function automatic int unsigned pipe_length();
    if (shadow_length == '0) return 1;
    if (shadow_length > MAX_SLOTS) return MAX_SLOTS;
    return shadow_length;
  endfunction

  task automatic report_failure(input string msg);
    fail_total++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic drop_oldest_slot();
    inflight_weight = inflight_weight - {{(LIMIT_W-WEIGHT_W){1'b0}}, slot_weights[oldest_slot]};
    oldest_slot = (oldest_slot + 1) % MAX_SLOTS;
    slots_in_flight--;
  endtask

  task automatic advance_pipe(input logic [WEIGHT_W-1:0] weight);
    slot_weights[(oldest_slot + slots_in_flight) % MAX_SLOTS] = weight;
    slots_in_flight++;
    inflight_weight = inflight_weight + {{(LIMIT_W-WEIGHT_W){1'b0}}, weight};
    run_ticks = add_saturating(run_ticks, 1);
  endtask

  // Works out the result of one truck and, unless it is rejected, moves the shadow pipe along.
  task automatic predict_admission(input logic [WEIGHT_W-1:0] weight, input logic first,
                                   output admission_t res);
    int unsigned len;
    int unsigned waited;
    int unsigned guard;
    len = pipe_length();
    waited = 0;
    guard = 0;
    res = '0;
    if (first) begin
      oldest_slot = 0;
      slots_in_flight = 0;
      inflight_weight = '0;
      run_ticks = '0;
    end
    if (weight > shadow_limit) begin
      res.rejected = 1'b1;
      return;
    end
    forever begin
      while (slots_in_flight >= len && slots_in_flight > 0) drop_oldest_slot();
      if (int'(inflight_weight) + int'(weight) <= int'(shadow_limit)) break;
      if (guard >= 2 * MAX_SLOTS + 2) break;
      guard++;
      advance_pipe('0);
      if (waited < 255) waited++;
    end
    advance_pipe(weight);
    res.entry_tick   = run_ticks;
    res.waited_ticks = waited[WAIT_W-1:0];
    res.drain_tick   = add_saturating(run_ticks, len);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_length     = PIPE_LEN_RST;
      shadow_limit      = LOAD_LIMIT_RST;
      oldest_slot       = 0;
      slots_in_flight   = 0;
      inflight_weight   = '0;
      run_ticks         = '0;
      expected_admissions.delete();
      fail_total        = 0;
      results_seen      = 0;
      rejects_seen      = 0;
      empty_ticks_total = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      result_count_o <= 0;
      reject_count_o <= 0;
      empty_ticks_o  <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_PIPE_LEN) shadow_length = pwdata[BLEN_W-1:0];
          else shadow_limit = pwdata[LIMIT_W-1:0];
        end else begin
          readback_want = (paddr[2] == REG_PIPE_LEN) ? DATA_W'(shadow_length)
                                                     : DATA_W'(shadow_limit);
          if (prdata !== readback_want)
            report_failure($sformatf("register readback at 0x%0h: got %0d, expected %0d",
                                     paddr, prdata, readback_want));
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        predict_admission(s_axis_tdata[WEIGHT_W-1:0], s_axis_tuser[0], predicted);
        empty_ticks_total += predicted.waited_ticks;
        expected_admissions.push_back(predicted);
      end

      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (m_axis_tuser[0]) rejects_seen++;
        if (expected_admissions.size() == 0) begin
          report_failure($sformatf("result with no truck pending (entry_tick %0d)",
                                   m_axis_tdata[31:0]));
        end else begin
          oldest = expected_admissions.pop_front();
          if (m_axis_tdata[31:0] !== oldest.entry_tick)
            report_failure($sformatf("result %0d entry_tick: got %0d, expected %0d",
                                     results_seen, m_axis_tdata[31:0], oldest.entry_tick));
          if (m_axis_tdata[39:32] !== oldest.waited_ticks)
            report_failure($sformatf("result %0d waited_ticks: got %0d, expected %0d",
                                     results_seen, m_axis_tdata[39:32], oldest.waited_ticks));
          if (m_axis_tdata[71:40] !== oldest.drain_tick)
            report_failure($sformatf("result %0d drain_tick: got %0d, expected %0d",
                                     results_seen, m_axis_tdata[71:40], oldest.drain_tick));
          if (m_axis_tuser[0] !== oldest.rejected)
            report_failure($sformatf("result %0d rejected: got %0d, expected %0d",
                                     results_seen, m_axis_tuser[0], oldest.rejected));
        end
      end

      fail_count_o   <= fail_total;
      pending_o      <= expected_admissions.size();
      result_count_o <= results_seen;
      reject_count_o <= rejects_seen;
      empty_ticks_o  <= empty_ticks_total;
    end
  end

endmodule

/* verif/fixed_latency_load_admission_top_tb.sv */
// Testbench top for the fixed-latency load admission block: clock, reset, stimulus
// on the truck stream and the APB port, random backpressure, and the verdict.
// Depends on fla_pkg, the block's RTL and fla_admission_checker.

module fixed_latency_load_admission_top_tb
  import fla_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SLOTS     = 128;
  localparam int unsigned RANDOM_TRUCKS = 600;
  // Cycles allowed after the last result, above the longest wait plus pipe shortening.
  localparam int unsigned SETTLE_CYCLES = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;   // [9:0] truck_weight, rest zero
  logic [0:0]        s_axis_tuser;   // [0] first
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [71:0]       m_axis_tdata;   // [31:0] entry_tick, [39:32] waited_ticks,
                                     // [71:40] drain_tick
  logic [0:0]        m_axis_tuser;   // [0] rejected
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned result_count;
  int unsigned reject_count;
  int unsigned empty_ticks;

  // Stimulus bookkeeping. The register values are tracked here only to shape weights.
  logic        tx_gaps_on;
  logic        rx_stalls_on;
  int unsigned trucks_sent;
  int unsigned directed_trucks;
  int unsigned register_writes;
  int unsigned cur_limit;

  always #5 clk_i = ~clk_i;

  fixed_latency_load_admission_top #(
    .MAX_SLOTS(MAX_SLOTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  fla_admission_checker #(
    .MAX_SLOTS(MAX_SLOTS)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending_results),
    .result_count_o(result_count),
    .reject_count_o(reject_count),
    .empty_ticks_o (empty_ticks)
  );

  // Gap lengths: mostly none, often short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result-side backpressure. All inputs change on the falling edge so the block and
  // the checker both see settled values at the rising edge.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (rx_stalls_on && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // One transfer on the truck stream. The valid stays high after the handshake so
  // that back-to-back trucks go in without a bubble; whoever comes next lowers it.
  task automatic send_truck(input logic [WEIGHT_W-1:0] weight, input logic first);
    int unsigned gap;
    @(negedge clk_i);
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(16-WEIGHT_W){1'b0}}, weight};
    s_axis_tuser  = first;
    do @(posedge clk_i); while (!s_axis_tready);
    trucks_sent++;
  endtask

  // Holds the stream idle until every predicted result has been returned.
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // APB write followed by a readback of the same register; the checker compares it.
  task automatic set_register(input logic reg_sel, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = '0;
    paddr[2] = reg_sel;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    register_writes++;
  endtask

  // Registers only change while no truck is waiting for its result.
  task automatic configure(input int unsigned length, input int unsigned limit);
    wait_for_results();
    set_register(REG_PIPE_LEN, DATA_W'(length));
    set_register(REG_LOAD_LIMIT, DATA_W'(limit));
    cur_limit = limit;
  endtask

  initial begin
    #15_000_000;
    $display("Timeout with %0d results still outstanding.", pending_results);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned random_sent;
    int unsigned phase_trucks;
    int unsigned run_left;
    int unsigned wmax;
    int unsigned len_sel;
    int unsigned limit_sel;
    int unsigned phase_len;
    int unsigned phase_limit;
    int unsigned mode;
    logic        keep_run;
    logic        first;
    logic [WEIGHT_W-1:0] weight;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    trucks_sent   = 0;
    register_writes = 0;
    cur_limit     = LOAD_LIMIT_RST;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, starting from the reset settings (two slots, limit ten).
    send_truck(10'd0, 1'b1);
    send_truck(10'd10, 1'b0);     // exactly at the limit, admitted at once behind the weightless truck
    send_truck(10'd11, 1'b0);     // heavier than the limit
    send_truck(10'd3, 1'b0);
    send_truck(10'd7, 1'b0);
    send_truck(10'd1023, 1'b1);   // overweight, but its first flag still clears the run
    send_truck(10'd10, 1'b0);

    // A zero length behaves as a one-slot pipe; largest limit, so no truck waits.
    configure(0, 131071);
    send_truck(10'd1023, 1'b1);
    send_truck(10'd1023, 1'b0);
    send_truck(10'd0, 1'b0);
    send_truck(10'd512, 1'b0);

    // A length above the slot count acts as the full pipe: the light truck behind a
    // full-weight one has to wait for it to cross all the slots.
    configure(255, 1023);
    send_truck(10'd1023, 1'b1);
    send_truck(10'd1, 1'b0);
    send_truck(10'd1022, 1'b0);

    configure(128, 2000);
    send_truck(10'd700, 1'b1);
    send_truck(10'd700, 1'b0);
    send_truck(10'd700, 1'b0);
    send_truck(10'd5, 1'b0);

    // Shorten the pipe in the middle of a run: the slots past the new end are dropped before the next truck goes in.
    configure(3, 2000);
    send_truck(10'd600, 1'b0);
    send_truck(10'd600, 1'b0);

    // A zero limit admits only weightless trucks.
    configure(1, 0);
    send_truck(10'd0, 1'b1);
    send_truck(10'd1, 1'b0);
    send_truck(10'd0, 1'b0);
    directed_trucks = trucks_sent;

    // Random part, in phases. Each phase picks a setting, a backpressure mode and a
    // number of runs; most runs start with a first flag and carry weights that fit
    // the limit, with some noise on top. Some phases keep the previous run going so
    // that a new length applies to a pipe that is still loaded.
    random_sent = 0;
    while (random_sent < RANDOM_TRUCKS) begin
      len_sel = $urandom_range(0, 9);
      case (len_sel)
        0:       phase_len = 0;
        1:       phase_len = 255;
        2:       phase_len = 128;
        3:       phase_len = $urandom_range(129, 255);
        4:       phase_len = $urandom_range(13, 127);
        default: phase_len = $urandom_range(1, 12);
      endcase
      limit_sel = $urandom_range(0, 9);
      case (limit_sel)
        0:       phase_limit = 0;
        1:       phase_limit = 131071;
        2:       phase_limit = 1023;
        3:       phase_limit = $urandom_range(0, 131071);
        default: phase_limit = $urandom_range(1, 2500);
      endcase
      configure(phase_len, phase_limit);

      mode = $urandom_range(0, 3);
      tx_gaps_on   = mode[0];
      rx_stalls_on = mode[1];
      keep_run     = ($urandom_range(0, 9) < 3);
      run_left     = keep_run ? $urandom_range(2, 10) : 0;
      wmax         = (cur_limit < 1023) ? cur_limit : 1023;
      phase_trucks = $urandom_range(20, 60);

      repeat (phase_trucks) begin
        first = 1'b0;
        if (run_left == 0) begin
          run_left = $urandom_range(3, 20);
          first    = 1'b1;
        end
        run_left--;
        if ($urandom_range(0, 9) == 0) begin
          weight = WEIGHT_W'($urandom_range(0, 1023));
          first  = 1'($urandom_range(0, 1));
        end else if ($urandom_range(0, 9) == 0) begin
          weight = WEIGHT_W'(wmax);
        end else begin
          weight = WEIGHT_W'($urandom_range(0, wmax));
        end
        send_truck(weight, first);
        random_sent++;
      end
    end

    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d trucks (%0d directed) over %0d register writes.",
             trucks_sent, directed_trucks, register_writes);
    $display("Checked %0d results: %0d rejected, %0d empty pipe ticks in total.",
             result_count, reject_count, empty_ticks);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("Found %0d mismatches.", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
